// ===== design/dose_coverage_statistics_defines.svh =====
// dose_coverage_statistics_defines.svh
// assertion macros for the dose coverage statistics block
// no dependencies; taken in by the top level only
`ifndef DOSE_COVERAGE_STATISTICS_DEFINES_SVH
`define DOSE_COVERAGE_STATISTICS_DEFINES_SVH

// implication in the same cycle, quiet while reset is asserted
`define DCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle, also checked during reset
`define DCS_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dcs_pkg.sv =====
// dcs_pkg.sv
// shared constants, register codes and helper functions of the dose coverage statistics block
// no dependencies
`default_nettype none

package dcs_pkg;

    localparam longint unsigned MAX_VOXELS_DEF = 64'd16777216;
    localparam int DOSE_BITS_DEF  = 16;

    localparam int NUM_LEVELS     = 8;
    localparam int LEVEL_IDX_BITS = 3;
    localparam int SUM_BITS       = 40;
    localparam int SUM_LO_BITS    = 32;
    localparam int INV_BITS       = 32;
    localparam int PRESC_BITS     = 16;
    localparam int PCT_BITS       = 7;
    localparam int REG_IDX_BITS   = 2;
    localparam int QUEUE_DEPTH    = 4;

    typedef logic [PCT_BITS-1:0] pct_t;

    localparam pct_t FULL_PCT = 7'd100;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_VOXEL_TOTAL   = 2'd0,
        REG_INVERSE_TOTAL = 2'd1,
        REG_PRESCRIPTION  = 2'd2
    } reg_idx_t;

    // coverage levels in percent of prescription
    function automatic pct_t level_pct(input logic [LEVEL_IDX_BITS-1:0] idx);
        pct_t pct;
        case (idx)
            3'd0:    pct = 7'd90;
            3'd1:    pct = 7'd95;
            3'd2:    pct = 7'd98;
            3'd3:    pct = 7'd100;
            3'd4:    pct = 7'd105;
            3'd5:    pct = 7'd107;
            3'd6:    pct = 7'd110;
            default: pct = 7'd120;
        endcase
        return pct;
    endfunction

    function automatic int cnt_bits(input longint unsigned max_v);
        return $clog2(max_v + 64'd1);
    endfunction

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== design/dose_coverage_statistics.sv =====
// a transaction passes the classify register, the queue, the multiply register and the result register
// throughput: one transaction per cycle while m_ready does not stall the output; set by the statistics update loop
// the back end holds up to two results and the queue four snapshots while m_ready is low
// reset (aresetn, synchronous, active low) clears the statistics, the queue and the
// configuration registers; no clearing pass, the block takes transactions straight away
`default_nettype none

`include "dose_coverage_statistics_defines.svh"

// dose_coverage_statistics.sv
// top level: configuration registers, front end, queue and back end
// depends on dcs_pkg, dcs_front, dcs_queue, dcs_back and the defines header
module dose_coverage_statistics #(
    parameter longint unsigned MAX_VOXELS = dcs_pkg::MAX_VOXELS_DEF,
    parameter int DOSE_BITS = dcs_pkg::DOSE_BITS_DEF,
    localparam int CNT_BITS = dcs_pkg::cnt_bits(MAX_VOXELS),
    localparam int CFG_W    = dcs_pkg::max_int(dcs_pkg::INV_BITS, CNT_BITS)
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [dcs_pkg::REG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]                 cfg_wdata,
    // dose samples
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [DOSE_BITS-1:0]             s_dose,
    input  wire logic                             s_start_new,
    // statistics results
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [DOSE_BITS-1:0]                  m_min_dose,
    output logic [DOSE_BITS-1:0]                  m_max_dose,
    output logic [DOSE_BITS-1:0]                  m_mean_dose,
    output logic [CNT_BITS-1:0]                   m_at_least_90,
    output logic [CNT_BITS-1:0]                   m_at_least_95,
    output logic [CNT_BITS-1:0]                   m_at_least_98,
    output logic [CNT_BITS-1:0]                   m_at_least_100,
    output logic [CNT_BITS-1:0]                   m_at_least_105,
    output logic [CNT_BITS-1:0]                   m_at_least_107,
    output logic [CNT_BITS-1:0]                   m_at_least_110,
    output logic [CNT_BITS-1:0]                   m_at_least_120
);

    // one snapshot: min, max, sum and the eight below counts
    localparam int SNAP_W = 2 * DOSE_BITS + dcs_pkg::SUM_BITS + dcs_pkg::NUM_LEVELS * CNT_BITS;

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    logic [CNT_BITS-1:0]            voxel_total_reg;
    logic [dcs_pkg::INV_BITS-1:0]   inverse_total_reg;
    logic [dcs_pkg::PRESC_BITS-1:0] prescription_reg;

    // front end to queue
    logic                           f_valid, q_wr_ready;
    logic [DOSE_BITS-1:0]           f_min, f_max;
    logic [dcs_pkg::SUM_BITS-1:0]   f_sum;
    logic [dcs_pkg::NUM_LEVELS-1:0][CNT_BITS-1:0] f_below;
    logic [SNAP_W-1:0]              q_wr_data, q_rd_data;

    // queue to back end
    logic                           q_rd_valid, b_ready;
    logic [DOSE_BITS-1:0]           b_min, b_max;
    logic [dcs_pkg::SUM_BITS-1:0]   b_sum;
    logic [dcs_pkg::NUM_LEVELS-1:0][CNT_BITS-1:0] b_below;
    logic [dcs_pkg::NUM_LEVELS-1:0][CNT_BITS-1:0] at_least;

    // register writes; an index outside the list is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voxel_total_reg   <= '0;
            inverse_total_reg <= '0;
            prescription_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (dcs_pkg::reg_idx_t'(cfg_index))
                dcs_pkg::REG_VOXEL_TOTAL: begin
                    voxel_total_reg <= cfg_wdata[CNT_BITS-1:0];
                end
                dcs_pkg::REG_INVERSE_TOTAL: begin
                    inverse_total_reg <= cfg_wdata[dcs_pkg::INV_BITS-1:0];
                end
                dcs_pkg::REG_PRESCRIPTION: begin
                    prescription_reg <= cfg_wdata[dcs_pkg::PRESC_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // classify against the coverage levels, then update the running statistics
    dcs_front #(
        .MAX_VOXELS (MAX_VOXELS),
        .DOSE_BITS  (DOSE_BITS),
        .CNT_BITS   (CNT_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_dose       (s_dose),
        .s_start_new  (s_start_new),
        .prescription (prescription_reg),
        .snap_valid   (f_valid),
        .snap_ready   (q_wr_ready),
        .snap_min     (f_min),
        .snap_max     (f_max),
        .snap_sum     (f_sum),
        .snap_below   (f_below)
    );

    assign q_wr_data = {f_min, f_max, f_sum, f_below};

    // snapshots wait here so the front keeps running while the result side stalls
    dcs_queue #(
        .WIDTH (SNAP_W),
        .DEPTH (dcs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (b_ready),
        .rd_data  (q_rd_data)
    );

    assign {b_min, b_max, b_sum, b_below} = q_rd_data;

    // mean and coverage counts, then the result register
    dcs_back #(
        .DOSE_BITS (DOSE_BITS),
        .CNT_BITS  (CNT_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (q_rd_valid),
        .in_ready      (b_ready),
        .in_min        (b_min),
        .in_max        (b_max),
        .in_sum        (b_sum),
        .in_below      (b_below),
        .voxel_total   (voxel_total_reg),
        .inverse_total (inverse_total_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_min         (m_min_dose),
        .m_max         (m_max_dose),
        .m_mean        (m_mean_dose),
        .m_at_least    (at_least)
    );

    // coverage outputs in level order
    assign m_at_least_90  = at_least[0];
    assign m_at_least_95  = at_least[1];
    assign m_at_least_98  = at_least[2];
    assign m_at_least_100 = at_least[3];
    assign m_at_least_105 = at_least[4];
    assign m_at_least_107 = at_least[5];
    assign m_at_least_110 = at_least[6];
    assign m_at_least_120 = at_least[7];

    // every result includes its own sample, so the extremes never cross
    `DCS_ASSERT_IMP(a_min_not_above_max, aclk, aresetn, m_valid, m_min_dose <= m_max_dose, "running minimum above running maximum")
    // a held snapshot with a full queue must stop the input side
    `DCS_ASSERT_IMP(a_full_queue_stalls, aclk, aresetn, f_valid && !q_wr_ready, !s_ready, "input taken while the queue is full")
    // after reset nothing is pending and the input side is open
    `DCS_ASSERT_NEXT(a_reset_empty, aclk, !aresetn, !m_valid && s_ready, "block not empty after reset")

endmodule

`default_nettype wire

// ===== design/dcs_front.sv =====
// dcs_front.sv
// front end: takes dose transactions, classifies them against the coverage levels
// and updates the running statistics; depends on dcs_pkg
`default_nettype none

module dcs_front #(
    parameter longint unsigned MAX_VOXELS = dcs_pkg::MAX_VOXELS_DEF,
    parameter int DOSE_BITS = dcs_pkg::DOSE_BITS_DEF,
    parameter int CNT_BITS  = dcs_pkg::cnt_bits(MAX_VOXELS)
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [DOSE_BITS-1:0]                  s_dose,
    input  wire logic                                  s_start_new,
    input  wire logic [dcs_pkg::PRESC_BITS-1:0]        prescription,
    output logic                                       snap_valid,
    input  wire logic                                  snap_ready,
    output logic [DOSE_BITS-1:0]                       snap_min,
    output logic [DOSE_BITS-1:0]                       snap_max,
    output logic [dcs_pkg::SUM_BITS-1:0]               snap_sum,
    output logic [dcs_pkg::NUM_LEVELS-1:0][CNT_BITS-1:0] snap_below
);

    localparam int CMP_W  = dcs_pkg::max_int(DOSE_BITS, dcs_pkg::PRESC_BITS) + dcs_pkg::PCT_BITS;
    localparam int SUM_W1 = dcs_pkg::SUM_BITS + 1;
    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_VOXELS);
    localparam logic [DOSE_BITS-1:0] DOSE_ONES = '1;
    localparam logic [dcs_pkg::SUM_BITS-1:0] SUM_ONES = '1;

    logic                               cls_valid_reg, cls_valid_next;
    logic [DOSE_BITS-1:0]               cls_dose_reg;
    logic                               cls_start_reg;
    logic [dcs_pkg::NUM_LEVELS-1:0]     cls_below_reg, cls_below_next;

    logic [DOSE_BITS-1:0]               min_reg, max_reg;
    logic [dcs_pkg::SUM_BITS-1:0]       sum_reg;
    logic [dcs_pkg::NUM_LEVELS-1:0][CNT_BITS-1:0] cnt_reg;

    logic [DOSE_BITS-1:0]               base_min, base_max;
    logic [dcs_pkg::SUM_BITS-1:0]       base_sum;
    logic [dcs_pkg::NUM_LEVELS-1:0][CNT_BITS-1:0] base_cnt;
    logic [SUM_W1-1:0]                  sum_wide;
    logic                               s_take, advance;

    assign s_ready    = !cls_valid_reg || snap_ready;
    assign s_take     = s_valid && s_ready;
    assign snap_valid = cls_valid_reg;
    assign advance    = cls_valid_reg && snap_ready;

    // dose*100 < prescription*pct, exact
    always_comb begin
        for (int k = 0; k < dcs_pkg::NUM_LEVELS; k++) begin
            cls_below_next[k] = (CMP_W'(s_dose) * CMP_W'(dcs_pkg::FULL_PCT))
                              < (CMP_W'(prescription)
                                 * CMP_W'(dcs_pkg::level_pct(dcs_pkg::LEVEL_IDX_BITS'(k))));
        end
        if (s_take) begin
            cls_valid_next = 1'b1;
        end else if (advance) begin
            cls_valid_next = 1'b0;
        end else begin
            cls_valid_next = cls_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cls_valid_reg <= 1'b0;
        end else begin
            cls_valid_reg <= cls_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            cls_dose_reg  <= s_dose;
            cls_start_reg <= s_start_new;
            cls_below_reg <= cls_below_next;
        end
    end

    // statistics update, start flag restarts from the cleared values
    always_comb begin
        base_min = cls_start_reg ? DOSE_ONES : min_reg;
        base_max = cls_start_reg ? '0 : max_reg;
        base_sum = cls_start_reg ? '0 : sum_reg;
        base_cnt = cls_start_reg ? '0 : cnt_reg;
        snap_min = (cls_dose_reg < base_min) ? cls_dose_reg : base_min;
        snap_max = (cls_dose_reg > base_max) ? cls_dose_reg : base_max;
        sum_wide = SUM_W1'(base_sum) + SUM_W1'(cls_dose_reg);
        snap_sum = sum_wide[dcs_pkg::SUM_BITS] ? SUM_ONES : sum_wide[dcs_pkg::SUM_BITS-1:0];
        for (int k = 0; k < dcs_pkg::NUM_LEVELS; k++) begin
            snap_below[k] = base_cnt[k]
                          + CNT_BITS'(cls_below_reg[k] && (base_cnt[k] < CNT_MAX));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= DOSE_ONES;
            max_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (advance) begin
            min_reg <= snap_min;
            max_reg <= snap_max;
            sum_reg <= snap_sum;
            cnt_reg <= snap_below;
        end
    end

endmodule

`default_nettype wire

// ===== design/dcs_queue.sv =====
// dcs_queue.sv
// short register queue between the front and back ends
// depends on dcs_pkg
`default_nettype none

module dcs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dcs_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] fifo_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push, pop;

    assign wr_ready = (fill_reg != CNT_FULL);
    assign rd_valid = (fill_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/dcs_back.sv =====
// dcs_back.sv
// back end: mean multiply, coverage subtraction and the result register
// depends on dcs_pkg
`default_nettype none

module dcs_back #(
    parameter int DOSE_BITS = dcs_pkg::DOSE_BITS_DEF,
    parameter int CNT_BITS  = dcs_pkg::cnt_bits(dcs_pkg::MAX_VOXELS_DEF)
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic [DOSE_BITS-1:0]                    in_min,
    input  wire logic [DOSE_BITS-1:0]                    in_max,
    input  wire logic [dcs_pkg::SUM_BITS-1:0]            in_sum,
    input  wire logic [dcs_pkg::NUM_LEVELS-1:0][CNT_BITS-1:0] in_below,
    input  wire logic [CNT_BITS-1:0]                     voxel_total,
    input  wire logic [dcs_pkg::INV_BITS-1:0]            inverse_total,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [DOSE_BITS-1:0]                         m_min,
    output logic [DOSE_BITS-1:0]                         m_max,
    output logic [DOSE_BITS-1:0]                         m_mean,
    output logic [dcs_pkg::NUM_LEVELS-1:0][CNT_BITS-1:0] m_at_least
);

    localparam int HI_BITS   = dcs_pkg::SUM_BITS - dcs_pkg::SUM_LO_BITS;
    localparam int HI_PROD_W = HI_BITS + dcs_pkg::INV_BITS;
    localparam int LO_PROD_W = dcs_pkg::SUM_LO_BITS + dcs_pkg::INV_BITS;
    localparam int MEAN_W    = HI_PROD_W + 1;
    localparam logic [MEAN_W-1:0] MEAN_CAP = MEAN_W'({DOSE_BITS{1'b1}});

    // multiply stage
    logic                       mul_valid_reg, mul_valid_next;
    logic [DOSE_BITS-1:0]       mul_min_reg, mul_max_reg;
    logic [HI_PROD_W-1:0]       prod_hi_reg;
    logic [LO_PROD_W-1:0]       prod_lo_reg;
    logic [dcs_pkg::NUM_LEVELS-1:0][CNT_BITS-1:0] atl_reg, atl_next;
    logic                       mul_ready, mul_take, mul_move;

    // result stage
    logic                       out_valid_reg, out_valid_next;
    logic [DOSE_BITS-1:0]       out_min_reg, out_max_reg, out_mean_reg, mean_next;
    logic [dcs_pkg::NUM_LEVELS-1:0][CNT_BITS-1:0] out_atl_reg;
    logic                       out_ready;
    logic [MEAN_W-1:0]          mean_wide;

    assign out_ready = !out_valid_reg || m_ready;
    assign mul_ready = !mul_valid_reg || out_ready;
    assign in_ready  = mul_ready;
    assign mul_take  = in_valid && mul_ready;
    assign mul_move  = mul_valid_reg && out_ready;

    always_comb begin
        for (int k = 0; k < dcs_pkg::NUM_LEVELS; k++) begin
            atl_next[k] = (voxel_total > in_below[k]) ? voxel_total - in_below[k] : '0;
        end
        if (mul_take) begin
            mul_valid_next = 1'b1;
        end else if (mul_move) begin
            mul_valid_next = 1'b0;
        end else begin
            mul_valid_next = mul_valid_reg;
        end
        if (mul_move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
        mean_wide = MEAN_W'(prod_hi_reg)
                  + MEAN_W'(prod_lo_reg[LO_PROD_W-1:dcs_pkg::SUM_LO_BITS]);
        mean_next = (mean_wide > MEAN_CAP) ? MEAN_CAP[DOSE_BITS-1:0]
                                           : mean_wide[DOSE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sum split in high and low words so each product stays within 32 by 32
    always_ff @(posedge aclk) begin
        if (mul_take) begin
            mul_min_reg <= in_min;
            mul_max_reg <= in_max;
            prod_hi_reg <= HI_PROD_W'(in_sum[dcs_pkg::SUM_BITS-1:dcs_pkg::SUM_LO_BITS])
                         * HI_PROD_W'(inverse_total);
            prod_lo_reg <= LO_PROD_W'(in_sum[dcs_pkg::SUM_LO_BITS-1:0])
                         * LO_PROD_W'(inverse_total);
            atl_reg     <= atl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_move) begin
            out_min_reg  <= mul_min_reg;
            out_max_reg  <= mul_max_reg;
            out_mean_reg <= mean_next;
            out_atl_reg  <= atl_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_min      = out_min_reg;
    assign m_max      = out_max_reg;
    assign m_mean     = out_mean_reg;
    assign m_at_least = out_atl_reg;

endmodule

`default_nettype wire
